// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/qhtq_pkg.sv =====
// Package for the quad heap timer queue: sizes, codes and shared structs.
// Depends on nothing.
package qhtq_pkg;
  localparam int unsigned Capacity   = 64;
  localparam int unsigned Arity      = 4;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned AddrW      = $clog2(Capacity);
  localparam int unsigned CountW     = $clog2(Capacity + 1);
  localparam int unsigned ArityW     = $clog2(Arity);
  localparam int unsigned ResCntW    = $clog2(MaxResults);
  localparam int unsigned EntryW     = 40;

  localparam logic OpAdd  = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [1:0] {
    KindAck    = 2'd0,
    KindExpire = 2'd1,
    KindSum    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  task_id;
  } entry_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now;
    logic [30:0] duration;
    logic [7:0]  task_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  woken_task;
    logic        new_earliest;
    logic        full_reject;
    logic        queue_empty;
    logic [31:0] next_delay;
    logic        last;
  } out_item_t;

  // Commands from controller to datapath.
  typedef enum logic [10:0] {
    CmdNone     = 11'b00000000001,
    CmdLoad     = 11'b00000000010, // latch input item
    CmdAppend   = 11'b00000000100, // write new entry at count, count++
    CmdUpRd     = 11'b00000001000, // read parent of pos
    CmdUpCmp    = 11'b00000010000, // compare, swap-write pos
    CmdUpWr     = 11'b00000100000, // write parent, move up
    CmdRootRd   = 11'b00001000000, // read root
    CmdPop      = 11'b00010000000, // read last entry, count--
    CmdPopWr    = 11'b00100000000, // write last entry to root as cur
    CmdDnRd     = 11'b01000000000, // read child pos*A+1+k
    CmdDnWr     = 11'b10000000000  // write best child to pos, move down
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [ArityW-1:0]   child;
    logic                dn_first;
    logic                dn_swap2;  // second write of a down swap
  } ctl_t;

  typedef struct packed {
    logic               opcode;
    logic               full;
    logic               empty;
    logic               up_done;    // pos is root or not smaller than parent
    logic               child_ok;   // child index k exists
    logic               dn_move;    // best child earlier than cur
    logic               root_due;
    logic               at_root;
  } sts_t;
endpackage

// ===== hdl/qhtq_if.sv =====
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
interface qhtq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/quad_heap_timer_queue.sv =====
// Top level of the quad heap timer queue: controller plus heap datapath.
// Depends on qhtq_pkg, qhtq_if, qhtq_ctrl, qhtq_datapath.
//
// Timer queue held as a four-child min-heap of (deadline, task) in a single
// port RAM with registered read. One item is handled at a time; the input
// stays blocked until the last result of the current item has transferred.
// An add is latched, decoded and appended at the end of the heap, then climbs
// with a parent read, a compare and a parent write per level; 64 entries form
// four heap levels, so a timer climbs at most three. A tick is decoded, then
// each pop runs a due check, root read, pop and root rewrite, then per level
// sunk up to four child reads through the one RAM port, a compare, then a
// two-write swap, before it settles at the final level and its result
// transfers. The summary adds a due check and its transfer. Every result
// transfer holds while the sink stalls. A tick pops at most 63 timers;
// remaining due timers wait for a later tick.
module quad_heap_timer_queue (
  input  logic clk_i,
  input  logic rst_ni,
  qhtq_if.sink   in_if,
  qhtq_if.source out_if
);
  import qhtq_pkg::*;

  ctl_t        ctl;
  sts_t        sts;
  kind_e       kind;
  logic        flag;
  logic [7:0]  woken;
  logic [31:0] delay;
  logic        earliest;
  out_item_t   res;

  qhtq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .ctl_o(ctl), .kind_o(kind), .flag_o(flag)
  );

  qhtq_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .item_i(in_if.data), .sts_o(sts),
    .woken_o(woken), .delay_o(delay), .earliest_o(earliest)
  );

  // Assemble the result, zeroing fields that do not apply to its kind.
  always_comb begin
    res = '0;
    res.kind = kind;
    case (kind)
      KindAck: begin
        res.full_reject  = flag;
        res.new_earliest = !flag && earliest;
        res.queue_empty  = sts.empty;
        res.next_delay   = delay;
        res.last         = 1'b1;
      end
      KindExpire: res.woken_task = woken;
      KindSum: begin
        res.queue_empty = sts.empty;
        res.next_delay  = delay;
        res.last        = 1'b1;
      end
      default: ;
    endcase
  end
  assign out_if.data = res;
endmodule

// ===== hdl/qhtq_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module qhtq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hdl/qhtq_datapath.sv =====
// Heap datapath: entry RAM, count, position and compare registers.
// Depends on qhtq_pkg, qhtq_ram, assert_macros.svh.
`include "assert_macros.svh"
module qhtq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qhtq_pkg::ctl_t      ctl_i,
  input  qhtq_pkg::in_item_t  item_i,
  output qhtq_pkg::sts_t      sts_o,
  output logic [7:0]          woken_o,
  output logic [31:0]         delay_o,
  output logic                earliest_o
);
  import qhtq_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  pos_q, pos_d, best_q, best_d;
  entry_t            cur_q, cur_d, best_e_q, best_e_d;
  logic              opcode_q;
  logic [31:0]       now_q;
  logic [31:0]       root_dl_q, root_dl_d;
  logic              root_ok_q, root_ok_d;
  logic              we;
  logic [AddrW-1:0]  addr;
  entry_t            wdata, rdata;
  logic [32:0]       sum;
  logic [31:0]       deadline;
  logic [AddrW-1:0]  parent;
  logic [CountW+ArityW:0] child_w;
  logic              dn_pend_q;
  logic [AddrW-1:0]  dn_addr_q;
  logic [7:0]        woken_q;

  assign sum      = {1'b0, item_i.now} + {2'b0, item_i.duration};
  assign deadline = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign parent   = AddrW'((pos_q - 1'b1) >> ArityW);
  assign child_w  = ({{(ArityW+1){1'b0}}, CountW'(pos_q)} << ArityW)
                    + (CountW+ArityW+1)'(ctl_i.child) + 1'b1;

  qhtq_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_comb begin
    we = 1'b0; addr = pos_q; wdata = cur_q;
    count_d = count_q; pos_d = pos_q; cur_d = cur_q;
    best_d = best_q; best_e_d = best_e_q;
    root_dl_d = root_dl_q; root_ok_d = root_ok_q;
    case (ctl_i.cmd)
      CmdLoad: begin
        cur_d = '{deadline: deadline, task_id: item_i.task_id};
      end
      CmdAppend: begin
        we = 1'b1; addr = AddrW'(count_q); wdata = cur_q;
        pos_d = AddrW'(count_q); count_d = count_q + 1'b1;
      end
      CmdUpRd: addr = parent;
      CmdUpCmp: begin
        if (!sts_o.up_done) begin
          we = 1'b1; addr = pos_q; wdata = rdata;
        end
      end
      CmdUpWr: begin
        we = 1'b1; addr = parent; wdata = cur_q; pos_d = parent;
      end
      CmdRootRd: addr = '0;
      CmdPop: begin
        addr = AddrW'(count_q - 1'b1); count_d = count_q - 1'b1;
      end
      CmdPopWr: begin
        cur_d = rdata; pos_d = '0;
        if (count_q != '0) begin
          we = 1'b1; addr = '0; wdata = rdata;
        end
      end
      CmdDnRd: begin
        addr = AddrW'(child_w);
        if (ctl_i.dn_first) begin
          best_e_d = cur_q; best_d = pos_q;
        end
      end
      CmdDnWr: begin
        if (ctl_i.dn_swap2) begin
          we = 1'b1; addr = best_q; wdata = cur_q; pos_d = best_q;
        end else begin
          we = 1'b1; addr = pos_q; wdata = best_e_q;
        end
      end
      default: ;
    endcase
    // Fold the child read issued last cycle into the running minimum.
    if (ctl_i.cmd != CmdDnRd && ctl_i.cmd != CmdPop && dn_pend_q
        && rdata.deadline < best_e_q.deadline) begin
      best_e_d = rdata; best_d = dn_addr_q;
    end
    if (ctl_i.cmd == CmdDnRd && !ctl_i.dn_first && dn_pend_q
        && rdata.deadline < best_e_q.deadline) begin
      best_e_d = rdata; best_d = dn_addr_q;
    end
    // Shadow the root deadline for delay computation.
    if (we && addr == '0) begin
      root_dl_d = wdata.deadline;
    end
    root_ok_d = (count_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; dn_pend_q <= 1'b0; root_ok_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dn_pend_q <= (ctl_i.cmd == CmdDnRd);
      root_ok_q <= root_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; cur_q <= cur_d; best_q <= best_d; best_e_q <= best_e_d;
    dn_addr_q <= AddrW'(child_w); root_dl_q <= root_dl_d;
    if (ctl_i.cmd == CmdLoad) begin
      opcode_q <= item_i.opcode; now_q <= item_i.now;
    end
    // Hold the popped root's task for the expire result.
    if (ctl_i.cmd == CmdPop) begin
      woken_q <= rdata.task_id;
    end
  end

  assign sts_o.opcode   = opcode_q;
  assign sts_o.full     = (count_q >= CountW'(Capacity));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.up_done  = (pos_q == '0) || !(cur_q.deadline < rdata.deadline);
  assign sts_o.child_ok = (child_w < (CountW+ArityW+1)'(count_q));
  assign sts_o.dn_move  = (best_d != pos_q) && (best_e_d.deadline < cur_q.deadline);
  assign sts_o.root_due = root_ok_q && (root_dl_q <= now_q);
  assign sts_o.at_root  = (pos_q == '0);
  assign woken_o    = woken_q;
  assign delay_o    = (!root_ok_q || root_dl_q <= now_q) ? 32'd0 : root_dl_q - now_q;
  assign earliest_o = (pos_q == '0);

  `ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CountW'(Capacity))
  `ASSERT_NEXT(a_pop_dec, clk_i, rst_ni, ctl_i.cmd == CmdPop, count_q == $past(count_q) - 1'b1)
  `ASSERT_IMPL(a_no_append_full, clk_i, rst_ni, ctl_i.cmd == CmdAppend, !sts_o.full)
endmodule

// ===== hdl/qhtq_ctrl.sv =====
// Controller: sequences insert, pop and result transfers.
// Depends on qhtq_pkg, assert_macros.svh.
`include "assert_macros.svh"
module qhtq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  qhtq_pkg::sts_t     sts_i,
  output qhtq_pkg::ctl_t     ctl_o,
  output qhtq_pkg::kind_e    kind_o,
  output logic               flag_o
);
  import qhtq_pkg::*;

  typedef enum logic [11:0] {
    SIdle   = 12'b000000000001,
    SDecide = 12'b000000000010,
    SUpRd   = 12'b000000000100,
    SUpCmp  = 12'b000000001000,
    SUpWr   = 12'b000000010000,
    SRootRd = 12'b000000100000,
    SCheck  = 12'b000001000000,
    SPop    = 12'b000010000000,
    SPopWr  = 12'b000100000000,
    SDnRd   = 12'b001000000000,
    SDnWr   = 12'b010000000000,
    SOut    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [ArityW:0]   k_q, k_d;
  logic              swap2_q, swap2_d;
  logic [ResCntW-1:0] nres_q, nres_d;
  kind_e             kind_q, kind_d;
  logic              flag_q, flag_d;
  logic              after_q, after_d; // return to SCheck after output

  always_comb begin
    state_d = state_q; k_d = k_q; swap2_d = swap2_q; nres_d = nres_q;
    kind_d = kind_q; flag_d = flag_q; after_d = after_q;
    ctl_o = '{cmd: CmdNone, child: ArityW'(k_q), dn_first: (k_q == '0),
              dn_swap2: swap2_q};
    in_ready_o = (state_q == SIdle);
    out_valid_o = (state_q == SOut);
    case (state_q)
      SIdle: if (in_valid_i) begin
        ctl_o.cmd = CmdLoad; state_d = SDecide; nres_d = '0;
      end
      SDecide: begin
        if (sts_i.opcode == OpAdd) begin
          if (sts_i.full) begin
            kind_d = KindAck; flag_d = 1'b1; after_d = 1'b0; state_d = SOut;
          end else begin
            ctl_o.cmd = CmdAppend; state_d = SUpRd;
          end
        end else begin
          state_d = SCheck;
        end
      end
      SUpRd: begin
        ctl_o.cmd = CmdUpRd; state_d = SUpCmp;
      end
      SUpCmp: begin
        ctl_o.cmd = CmdUpCmp;
        if (sts_i.up_done) begin
          kind_d = KindAck; flag_d = 1'b0; after_d = 1'b0; state_d = SOut;
        end else begin
          state_d = SUpWr;
        end
      end
      SUpWr: begin
        ctl_o.cmd = CmdUpWr; state_d = SUpRd;
      end
      SCheck: begin
        if (sts_i.root_due && nres_q != ResCntW'(MaxResults - 1)) begin
          state_d = SRootRd;
        end else begin
          kind_d = KindSum; after_d = 1'b0; state_d = SOut;
        end
      end
      SRootRd: begin
        ctl_o.cmd = CmdRootRd; state_d = SPop;
      end
      SPop: begin
        ctl_o.cmd = CmdPop; state_d = SPopWr;
      end
      SPopWr: begin
        ctl_o.cmd = CmdPopWr; k_d = '0; state_d = SDnRd;
      end
      SDnRd: begin
        if (k_q != (ArityW+1)'(Arity) && sts_i.child_ok) begin
          ctl_o.cmd = CmdDnRd; k_d = k_q + 1'b1;
        end else if (k_q != '0 && sts_i.dn_move) begin
          state_d = SDnWr; swap2_d = 1'b0;
        end else begin
          kind_d = KindExpire; after_d = 1'b1; state_d = SOut;
        end
      end
      SDnWr: begin
        ctl_o.cmd = CmdDnWr;
        if (swap2_q) begin
          k_d = '0; state_d = SDnRd;
        end
        swap2_d = !swap2_q;
      end
      SOut: if (out_ready_i) begin
        nres_d = nres_q + 1'b1;
        state_d = after_q ? SCheck : SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; k_q <= '0; swap2_q <= 1'b0; nres_q <= '0;
      kind_q <= KindAck; flag_q <= 1'b0; after_q <= 1'b0;
    end else begin
      state_q <= state_d; k_q <= k_d; swap2_q <= swap2_d; nres_q <= nres_d;
      kind_q <= kind_d; flag_q <= flag_d; after_q <= after_d;
    end
  end

  assign kind_o = kind_q;
  assign flag_o = flag_q;

  `ASSERT_IMPL(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `ASSERT_IMPL(a_expire_only_tick, clk_i, rst_ni, out_valid_o && kind_q == KindExpire, sts_i.opcode == OpTick)
  `ASSERT_IMPL(a_no_in_busy, clk_i, rst_ni, out_valid_o, !in_ready_o)
endmodule
